// ===== rtl/gsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gsp_pkg;

  // serial link framing
  localparam int unsigned NUM_BYTES     = 5;
  localparam int unsigned BYTE_IDX_W    = 3;
  localparam int unsigned BIT_IDX_W     = 3;
  localparam int unsigned HALF_W        = 16;

  // command bytes of one poll
  localparam logic [7:0] CMD_BYTE_0     = 8'h01;
  localparam logic [7:0] CMD_BYTE_1     = 8'h42;
  localparam logic [7:0] CMD_BYTE_REST  = 8'h00;

  // byte positions that carry the button bytes
  localparam logic [BYTE_IDX_W-1:0] BYTE_IDX_LOW_BTN  = 3'd3;
  localparam logic [BYTE_IDX_W-1:0] BYTE_IDX_HIGH_BTN = 3'd4;
  localparam logic [BYTE_IDX_W-1:0] BYTE_IDX_LAST     = 3'd4;
  localparam logic [BIT_IDX_W-1:0]  BIT_IDX_LAST      = 3'd7;

  // reset values
  localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd50;
  localparam logic [7:0]        BUTTONS_RESET     = 8'hFF;

  // one result item
  typedef struct packed {
    logic       cmd_level;
    logic       clk_level;
    logic       att_level;
    logic       done_res;
    logic [7:0] pad_byte;
    logic [7:0] buttons_low;
    logic [7:0] buttons_high;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/gsp_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gsp_seq (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic                        start_req,
  input  wire logic                        data_in,
  input  wire logic [gsp_pkg::HALF_W-1:0]  half_ticks,
  output gsp_pkg::result_t                 res
);

  logic                                busy_r, busy_nxt;
  logic [gsp_pkg::BYTE_IDX_W-1:0]      byte_r, byte_nxt;
  logic [gsp_pkg::BIT_IDX_W-1:0]       bit_r, bit_nxt;
  logic                                phase_low_r, phase_low_nxt;
  logic [gsp_pkg::HALF_W-1:0]          tick_r, tick_nxt;
  logic [7:0]                          shift_r, shift_nxt;
  logic [7:0]                          low_btn_r, low_btn_nxt;
  logic [7:0]                          high_btn_r, high_btn_nxt;

  logic                                start_now;
  logic                                busy_c;
  logic [gsp_pkg::BYTE_IDX_W-1:0]      byte_c;
  logic [gsp_pkg::BIT_IDX_W-1:0]       bit_c;
  logic                                phase_low_c;
  logic [gsp_pkg::HALF_W-1:0]          tick_c;
  logic [7:0]                          shift_c;
  logic [gsp_pkg::HALF_W-1:0]          half_eff;
  logic                                half_end;
  logic [7:0]                          cur_byte;
  logic                                done_c;

  // command byte for a byte position, zero beyond the last
  function automatic logic [7:0] cmd_byte(input logic [gsp_pkg::BYTE_IDX_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = gsp_pkg::CMD_BYTE_0;
      3'd1:    b = gsp_pkg::CMD_BYTE_1;
      default: b = gsp_pkg::CMD_BYTE_REST;
    endcase
    return b;
  endfunction

  // active-low button bytes to pressed-button pad byte
  function automatic logic [7:0] pad_map(input logic [7:0] lo_n, input logic [7:0] hi_n);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = ~lo_n;
    hi = ~hi_n;
    return {hi[6], hi[7], lo[0], lo[3], lo[4], lo[6], lo[7], lo[5]};
  endfunction

  // a start while idle takes effect on this same tick
  assign start_now   = !busy_r && start_req;
  assign busy_c      = busy_r | start_now;
  assign byte_c      = start_now ? '0 : byte_r;
  assign bit_c       = start_now ? '0 : bit_r;
  assign phase_low_c = start_now ? 1'b1 : phase_low_r;
  assign tick_c      = start_now ? '0 : tick_r;
  assign shift_c     = start_now ? '0 : shift_r;

  // zero half period acts as one tick
  assign half_eff = (half_ticks == '0) ? {{(gsp_pkg::HALF_W-1){1'b0}}, 1'b1} : half_ticks;
  assign half_end = ({1'b0, tick_c} + {{gsp_pkg::HALF_W{1'b0}}, 1'b1}) >= {1'b0, half_eff};
  assign cur_byte = cmd_byte(byte_c);

  // bit timing and byte sequencing
  always_comb begin
    busy_nxt      = busy_c;
    byte_nxt      = byte_c;
    bit_nxt       = bit_c;
    phase_low_nxt = phase_low_c;
    tick_nxt      = tick_c;
    shift_nxt     = shift_c;
    low_btn_nxt   = low_btn_r;
    high_btn_nxt  = high_btn_r;
    done_c        = 1'b0;
    if (busy_c) begin
      if (half_end) begin
        tick_nxt = '0;
        if (phase_low_c) begin
          // sample the data line at the end of the low half
          if (data_in) begin
            shift_nxt = shift_c | (8'd1 << bit_c);
          end
          phase_low_nxt = 1'b0;
        end else begin
          phase_low_nxt = 1'b1;
          if (bit_c == gsp_pkg::BIT_IDX_LAST) begin
            if (byte_c == gsp_pkg::BYTE_IDX_LOW_BTN) begin
              low_btn_nxt = shift_c;
            end else if (byte_c == gsp_pkg::BYTE_IDX_HIGH_BTN) begin
              high_btn_nxt = shift_c;
            end
            shift_nxt = '0;
            bit_nxt   = '0;
            if (byte_c >= gsp_pkg::BYTE_IDX_LAST) begin
              busy_nxt      = 1'b0;
              byte_nxt      = '0;
              phase_low_nxt = 1'b0;
              done_c        = 1'b1;
            end else begin
              byte_nxt = byte_c + 1'b1;
            end
          end else begin
            bit_nxt = bit_c + 1'b1;
          end
        end
      end else begin
        tick_nxt = tick_c + 1'b1;
      end
    end
  end

  // line levels and stored bytes for this tick
  always_comb begin
    res.cmd_level    = 1'b1;
    res.clk_level    = 1'b1;
    res.att_level    = 1'b1;
    if (busy_c) begin
      res.cmd_level = cur_byte[bit_c];
      res.clk_level = !phase_low_c;
      res.att_level = 1'b0;
    end
    res.done_res     = done_c;
    res.pad_byte     = pad_map(low_btn_nxt, high_btn_nxt);
    res.buttons_low  = low_btn_nxt;
    res.buttons_high = high_btn_nxt;
  end

  // state advances once per transferred tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      byte_r      <= '0;
      bit_r       <= '0;
      phase_low_r <= 1'b0;
      tick_r      <= '0;
      shift_r     <= '0;
      low_btn_r   <= gsp_pkg::BUTTONS_RESET;
      high_btn_r  <= gsp_pkg::BUTTONS_RESET;
    end else if (step) begin
      busy_r      <= busy_nxt;
      byte_r      <= byte_nxt;
      bit_r       <= bit_nxt;
      phase_low_r <= phase_low_nxt;
      tick_r      <= tick_nxt;
      shift_r     <= shift_nxt;
      low_btn_r   <= low_btn_nxt;
      high_btn_r  <= high_btn_nxt;
    end
  end

  // idle leaves the bit counters and clock phase cleared
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (byte_r == '0 && bit_r == '0 && !phase_low_r))
    else $error("idle with sequencing state not cleared");

  // byte position never runs past the last byte
  a_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_r <= gsp_pkg::BYTE_IDX_LAST)
    else $error("byte index out of range");

  // done only at the close of a high half, with attention still low
  a_done_levels: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.done_res) |-> (res.clk_level && !res.att_level))
    else $error("done on wrong line levels");

  // a finished poll leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.done_res) |=> !busy_r)
    else $error("still busy after done");

endmodule

`default_nettype wire

// ===== rtl/gsp_out.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gsp_out (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire gsp_pkg::result_t res_in,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic                  free,
  output gsp_pkg::result_t      res_out
);

  logic             valid_r, valid_nxt;
  gsp_pkg::result_t data_r;

  // room when empty or when the held result leaves this cycle
  assign free = !valid_r || out_ready;

  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = data_r;

endmodule

`default_nettype wire

// ===== rtl/gamepad_serial_poller_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Gamepad poller on a four-wire serial link. Each transfer on the in_ channel is one
// tick of time and yields exactly one result on the out_ channel, one tick per clock
// cycle unless out_ready stalls; a result appears the cycle after its tick, held in a
// single result register that refills in the cycle it is drained. A start request
// while idle pulls attention low and shifts out 0x01 0x42 0x00 0x00 0x00 LSB first,
// each bit a low clock half (data sampled on its last tick) and a high clock half of
// cfg_half_period_ticks ticks each (0 acts as 1). The fourth and fifth received bytes
// are kept as the active-low button bytes and mapped to pad_byte; done_res marks the
// last tick of a poll. Write the configuration only while idle.
module gamepad_serial_poller_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input ticks
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_start_req,
  input  wire logic        in_data_in,
  // results
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_cmd_level,
  output logic             out_clk_level,
  output logic             out_att_level,
  output logic             out_done_res,
  output logic [7:0]       out_pad_byte,
  output logic [7:0]       out_buttons_low,
  output logic [7:0]       out_buttons_high,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_half_period_ticks
);

  logic [gsp_pkg::HALF_W-1:0] half_r;
  logic                       step;
  logic                       free;
  gsp_pkg::result_t           res_c;
  gsp_pkg::result_t           res_q;

  // configuration register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= gsp_pkg::HALF_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      half_r <= cfg_half_period_ticks;
    end
  end

  // tick transfer
  assign in_ready = free;
  assign step     = in_valid && in_ready;

  gsp_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .start_req  (in_start_req),
    .data_in    (in_data_in),
    .half_ticks (half_r),
    .res        (res_c)
  );

  gsp_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res_in    (res_c),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (free),
    .res_out   (res_q)
  );

  assign out_cmd_level    = res_q.cmd_level;
  assign out_clk_level    = res_q.clk_level;
  assign out_att_level    = res_q.att_level;
  assign out_done_res     = res_q.done_res;
  assign out_pad_byte     = res_q.pad_byte;
  assign out_buttons_low  = res_q.buttons_low;
  assign out_buttons_high = res_q.buttons_high;

endmodule

`default_nettype wire

// ===== tb/gamepad_serial_poller_top_tb.sv =====
`timescale 1ns / 1ps

module gamepad_serial_poller_top_tb;

  localparam int unsigned N_PHASES        = 6;
  localparam int unsigned TICKS_PER_PHASE = 100;

  // data line patterns for random phases
  typedef enum int unsigned {
    DATA_RANDOM,
    DATA_MOSTLY_HIGH,
    DATA_MOSTLY_LOW
  } data_mode_t;

  // tracks the poll sequencer and queues the line levels expected per tick
  class poll_tracker_t;
    logic [gsp_pkg::HALF_W-1:0]     half_cfg;
    bit                             busy;
    logic [gsp_pkg::BYTE_IDX_W-1:0] byte_idx;
    logic [gsp_pkg::BIT_IDX_W-1:0]  bit_idx;
    bit                             phase_low;
    logic [gsp_pkg::HALF_W-1:0]     tick_cnt;
    logic [7:0]                     shift_reg;
    logic [7:0]                     btn_lo;
    logic [7:0]                     btn_hi;
    logic [7:0]                     cmd_seq [gsp_pkg::NUM_BYTES];
    gsp_pkg::result_t               pending_results[$];
    int unsigned                    errors;
    int unsigned                    ticks;
    int unsigned                    polls;
    int unsigned                    settings;

    function new();
      half_cfg  = gsp_pkg::HALF_PERIOD_RESET;
      busy      = 1'b0;
      byte_idx  = '0;
      bit_idx   = '0;
      phase_low = 1'b0;
      tick_cnt  = '0;
      shift_reg = '0;
      btn_lo    = gsp_pkg::BUTTONS_RESET;
      btn_hi    = gsp_pkg::BUTTONS_RESET;
      cmd_seq   = '{gsp_pkg::CMD_BYTE_0, gsp_pkg::CMD_BYTE_1, gsp_pkg::CMD_BYTE_REST,
                    gsp_pkg::CMD_BYTE_REST, gsp_pkg::CMD_BYTE_REST};
      errors    = 0;
      ticks     = 0;
      polls     = 0;
      settings  = 0;
    endfunction

    function void set_half(logic [gsp_pkg::HALF_W-1:0] v);
      half_cfg = v;
      settings++;
    endfunction

    // active-low button bytes to pressed-button pad byte
    function logic [7:0] pad_map();
      logic [7:0] lo;
      logic [7:0] hi;
      lo = ~btn_lo;
      hi = ~btn_hi;
      return {hi[6], hi[7], lo[0], lo[3], lo[4], lo[6], lo[7], lo[5]};
    endfunction

    // advance one tick and queue the line levels it produces
    function void note_tick(bit start, bit din);
      gsp_pkg::result_t r;
      logic [7:0]       cmd_byte;
      int unsigned      half;
      r.cmd_level = 1'b1;
      r.clk_level = 1'b1;
      r.att_level = 1'b1;
      r.done_res  = 1'b0;
      if (!busy && start) begin
        busy      = 1'b1;
        byte_idx  = '0;
        bit_idx   = '0;
        phase_low = 1'b1;
        tick_cnt  = '0;
        shift_reg = '0;
      end
      if (busy) begin
        cmd_byte    = (byte_idx < gsp_pkg::NUM_BYTES) ? cmd_seq[byte_idx] : 8'h00;
        r.att_level = 1'b0;
        r.clk_level = !phase_low;
        r.cmd_level = cmd_byte[bit_idx];
        half = (half_cfg == '0) ? 1 : int'(half_cfg);
        if (int'(tick_cnt) + 1 >= half) begin
          tick_cnt = '0;
          if (phase_low) begin
            // sample on the last tick of the low half
            if (din) shift_reg[bit_idx] = 1'b1;
            phase_low = 1'b0;
          end else begin
            phase_low = 1'b1;
            if (bit_idx == gsp_pkg::BIT_IDX_LAST) begin
              if (byte_idx == gsp_pkg::BYTE_IDX_LOW_BTN) btn_lo = shift_reg;
              else if (byte_idx == gsp_pkg::BYTE_IDX_HIGH_BTN) btn_hi = shift_reg;
              shift_reg = '0;
              bit_idx   = '0;
              if (byte_idx >= gsp_pkg::BYTE_IDX_LAST) begin
                busy       = 1'b0;
                byte_idx   = '0;
                phase_low  = 1'b0;
                r.done_res = 1'b1;
                polls++;
              end else begin
                byte_idx++;
              end
            end else begin
              bit_idx++;
            end
          end
        end else begin
          tick_cnt++;
        end
      end
      r.pad_byte     = pad_map();
      r.buttons_low  = btn_lo;
      r.buttons_high = btn_hi;
      ticks++;
      pending_results.push_back(r);
    endfunction

    task report(string what);
      $display("[%0t] ERROR %s", $time, what);
      errors++;
    endtask

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_result(gsp_pkg::result_t got);
      gsp_pkg::result_t want;
      if (pending_results.size() == 0) begin
        report("result transfer with no tick outstanding");
        return;
      end
      want = pending_results.pop_front();
      check_field("cmd_level", 8'(got.cmd_level), 8'(want.cmd_level));
      check_field("clk_level", 8'(got.clk_level), 8'(want.clk_level));
      check_field("att_level", 8'(got.att_level), 8'(want.att_level));
      check_field("done_res", 8'(got.done_res), 8'(want.done_res));
      check_field("pad_byte", got.pad_byte, want.pad_byte);
      check_field("buttons_low", got.buttons_low, want.buttons_low);
      check_field("buttons_high", got.buttons_high, want.buttons_high);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  wire         in_ready;
  logic        in_start_req;
  logic        in_data_in;
  wire         out_valid;
  logic        out_ready;
  wire         out_cmd_level;
  wire         out_clk_level;
  wire         out_att_level;
  wire         out_done_res;
  wire  [7:0]  out_pad_byte;
  wire  [7:0]  out_buttons_low;
  wire  [7:0]  out_buttons_high;
  logic        cfg_valid;
  wire         cfg_ready;
  logic [15:0] cfg_half_period_ticks;

  bit               idle_on;
  gsp_pkg::result_t out_line;
  poll_tracker_t    tracker = new();

  gamepad_serial_poller_top u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_start_req          (in_start_req),
    .in_data_in            (in_data_in),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_cmd_level         (out_cmd_level),
    .out_clk_level         (out_clk_level),
    .out_att_level         (out_att_level),
    .out_done_res          (out_done_res),
    .out_pad_byte          (out_pad_byte),
    .out_buttons_low       (out_buttons_low),
    .out_buttons_high      (out_buttons_high),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_half_period_ticks (cfg_half_period_ticks)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watch both channels at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.note_tick(in_start_req, in_data_in);
      if (out_valid && out_ready) begin
        out_line.cmd_level    = out_cmd_level;
        out_line.clk_level    = out_clk_level;
        out_line.att_level    = out_att_level;
        out_line.done_res     = out_done_res;
        out_line.pad_byte     = out_pad_byte;
        out_line.buttons_low  = out_buttons_low;
        out_line.buttons_high = out_buttons_high;
        tracker.check_result(out_line);
      end
    end
  end

  // result side back-pressure in random bursts
  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // one tick transfer, with an occasional gap ahead of it
  task automatic send_tick(bit start, bit din);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_start_req <= start;
    in_data_in   <= din;
    do @(posedge clk); while (!in_ready);
  endtask

  // let any running poll end, then wait for every result
  task automatic finish_phase();
    send_tick(1'b0, 1'($urandom_range(0, 1)));
    while (tracker.busy) send_tick(1'b0, 1'($urandom_range(0, 1)));
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_half(logic [15:0] v);
    cfg_valid             <= 1'b1;
    cfg_half_period_ticks <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_half(v);
  endtask

  task automatic run_random(int unsigned count, data_mode_t mode);
    bit din;
    for (int unsigned i = 0; i < count; i++) begin
      case (mode)
        DATA_MOSTLY_HIGH: din = ($urandom_range(0, 15) != 0);
        DATA_MOSTLY_LOW:  din = ($urandom_range(0, 15) == 0);
        default:          din = 1'($urandom_range(0, 1));
      endcase
      send_tick($urandom_range(0, 7) == 0, din);
    end
  endtask

  function automatic logic [15:0] pick_half();
    case ($urandom_range(0, 9))
      0:          return 16'd0;
      1, 2, 3, 4: return 16'd1;
      5, 6:       return 16'd2;
      7:          return 16'd3;
      8:          return 16'($urandom_range(4, 6));
      default:    return 16'($urandom_range(7, 9));
    endcase
  endfunction

  initial begin
    data_mode_t mode;
    in_valid              = 1'b0;
    in_start_req          = 1'b0;
    in_data_in            = 1'b0;
    cfg_valid             = 1'b0;
    cfg_half_period_ticks = '0;
    idle_on               = 1'b0;
    rst_n                 = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle ticks at the reset half period: lines parked, reset button bytes
    for (int i = 0; i < 6; i++) send_tick(1'b0, 1'(i));
    finish_phase();

    // zero half period acts as one; start held through busy and done ticks
    write_half(16'd0);
    for (int i = 0; i < 170; i++) send_tick(1'b1, 1'b1);
    finish_phase();

    // every button pressed
    write_half(16'd1);
    for (int i = 0; i < 85; i++) send_tick(i == 0, 1'b0);
    finish_phase();

    // widest half period, idle only
    write_half(16'hFFFF);
    for (int i = 0; i < 4; i++) send_tick(1'b0, 1'(i));
    finish_phase();

    // random phases, the last one without gaps or stalls
    for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
      if (ph == N_PHASES - 1) write_half(16'($urandom_range(1, 3)));
      else write_half(pick_half());
      idle_on = (ph != N_PHASES - 1) && (ph % 4 != 2);
      case ($urandom_range(0, 3))
        0:       mode = DATA_MOSTLY_HIGH;
        1:       mode = DATA_MOSTLY_LOW;
        default: mode = DATA_RANDOM;
      endcase
      run_random(TICKS_PER_PHASE, mode);
      finish_phase();
    end
    idle_on = 1'b0;

    repeat (4) @(posedge clk);
    if (tracker.pending_results.size() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.pending_results.size()));

    $display("Ran %0d ticks, %0d complete polls, %0d half-period writes",
             tracker.ticks, tracker.polls, tracker.settings);
    if (tracker.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gsp_pkg.sv
rtl/gsp_seq.sv
rtl/gsp_out.sv
rtl/gamepad_serial_poller_top.sv
tb/gamepad_serial_poller_top_tb.sv
